// File: rtl/spi_flash_challenge_responder_unit_defines.svh
// Assertion macros used by the responder RTL.
// Needs a clock named clk and a synchronous reset named rst in the including module.
`ifndef SPI_FLASH_CHALLENGE_RESPONDER_UNIT_DEFINES_SVH
`define SPI_FLASH_CHALLENGE_RESPONDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising edge of clk outside reset.
`define SFCR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sfcr: property check failed");

// Checks that a condition never holds outside reset.
`define SFCR_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("sfcr: forbidden condition seen");

`else

`define SFCR_ASSERT(label, prop)
`define SFCR_NEVER(label, cond)

`endif

`endif

// File: rtl/sfcr_pkg.sv
`timescale 1ns / 1ps
// Shared types, command codes and the challenge coding table for the responder.
// No dependencies; imported by the top level and the sequencer.
package sfcr_pkg;

  // Input beat: one SPI byte, one device ID load, or a deselect.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic [5:0] id_index;
    logic [6:0] id_value;
  } in_t;

  // Result beat: the byte to shift out next and the run flag.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       in_run;
  } out_t;

  // Where the result byte comes from once the item reaches the second stage.
  typedef enum logic [1:0] {
    SRC_DIRECT,
    SRC_ID,
    SRC_CODED
  } src_t;

  // Work handed from the sequencer to the pipeline register.
  typedef struct packed {
    src_t       src;
    logic [7:0] byte_val;
    logic [6:0] pos;
    logic       in_run;
  } issue_t;

  // Input function codes.
  localparam logic [1:0] FUNC_BYTE     = 2'd0;
  localparam logic [1:0] FUNC_LOAD     = 2'd1;
  localparam logic [1:0] FUNC_DESELECT = 2'd2;

  // Commands recognized in the command phase.
  localparam logic [7:0] CMD_READ_STATUS = 8'hD7;
  localparam logic [7:0] CMD_DUMP        = 8'h77;

  // Run lengths.
  localparam int CHALLENGE_LEN = 128;
  localparam int LEAD_ZEROS    = 3;

  // Configuration registers.
  localparam int          CFG_IDX_W    = 2;
  localparam int          CFG_DATA_W   = 24;
  localparam logic [1:0]  REG_SERIAL   = 2'd0;
  localparam logic [1:0]  REG_STATUS   = 2'd1;
  localparam logic [23:0] SERIAL_RESET = 24'h9A2F21;
  localparam logic [7:0]  STATUS_RESET = 8'h8C;

  // Coding table for the middle part of the challenge.
  localparam logic [7:0] CODE_TABLE [256] = '{
    8'h00,8'h04,8'h08,8'h0C,8'h10,8'h14,8'h18,8'h1C,8'h21,8'h25,8'h29,8'h2D,8'h31,8'h35,8'h39,8'h3D,
    8'h46,8'h42,8'h4E,8'h4A,8'h56,8'h52,8'h5E,8'h5A,8'h67,8'h63,8'h6F,8'h6B,8'h77,8'h73,8'h7F,8'h7B,
    8'h8C,8'h88,8'h84,8'h80,8'h9C,8'h98,8'h94,8'h90,8'hAD,8'hA9,8'hA5,8'hA1,8'hBD,8'hB9,8'hB5,8'hB1,
    8'hCA,8'hCE,8'hC2,8'hC6,8'hDA,8'hDE,8'hD2,8'hD6,8'hEB,8'hEF,8'hE3,8'hE7,8'hFB,8'hFF,8'hF3,8'hF7,
    8'h18,8'h1C,8'h10,8'h14,8'h08,8'h0C,8'h00,8'h04,8'h39,8'h3D,8'h31,8'h35,8'h29,8'h2D,8'h21,8'h25,
    8'h5E,8'h5A,8'h56,8'h52,8'h4E,8'h4A,8'h46,8'h42,8'h7F,8'h7B,8'h77,8'h73,8'h6F,8'h6B,8'h67,8'h63,
    8'h94,8'h90,8'h9C,8'h98,8'h84,8'h80,8'h8C,8'h88,8'hB5,8'hB1,8'hBD,8'hB9,8'hA5,8'hA1,8'hAD,8'hA9,
    8'hD2,8'hD6,8'hDA,8'hDE,8'hC2,8'hC6,8'hCA,8'hCE,8'hF3,8'hF7,8'hFB,8'hFF,8'hE3,8'hE7,8'hEB,8'hEF,
    8'h31,8'h35,8'h39,8'h3D,8'h21,8'h25,8'h29,8'h2D,8'h10,8'h14,8'h18,8'h1C,8'h00,8'h04,8'h08,8'h0C,
    8'h77,8'h73,8'h7F,8'h7B,8'h67,8'h63,8'h6F,8'h6B,8'h56,8'h52,8'h5E,8'h5A,8'h46,8'h42,8'h4E,8'h4A,
    8'hBD,8'hB9,8'hB5,8'hB1,8'hAD,8'hA9,8'hA5,8'hA1,8'h9C,8'h98,8'h94,8'h90,8'h8C,8'h88,8'h84,8'h80,
    8'hFB,8'hFF,8'hF3,8'hF7,8'hEB,8'hEF,8'hE3,8'hE7,8'hDA,8'hDE,8'hD2,8'hD6,8'hCA,8'hCE,8'hC2,8'hC6,
    8'h29,8'h2D,8'h21,8'h25,8'h39,8'h3D,8'h31,8'h35,8'h08,8'h0C,8'h00,8'h04,8'h18,8'h1C,8'h10,8'h14,
    8'h6F,8'h6B,8'h67,8'h63,8'h7F,8'h7B,8'h77,8'h73,8'h4E,8'h4A,8'h46,8'h42,8'h5E,8'h5A,8'h56,8'h52,
    8'hA5,8'hA1,8'hAD,8'hA9,8'hB5,8'hB1,8'hBD,8'hB9,8'h84,8'h80,8'h8C,8'h88,8'h94,8'h90,8'h9C,8'h98,
    8'hE3,8'hE7,8'hEB,8'hEF,8'hF3,8'hF7,8'hFB,8'hFF,8'hC2,8'hC6,8'hCA,8'hCE,8'hD2,8'hD6,8'hDA,8'hDE
  };

endpackage

// File: rtl/spi_flash_challenge_responder_unit.sv
`timescale 1ns / 1ps
// SPI flash challenge responder, top level: config registers, sequencer, ID store, output stage.
// Two register stages, set by the ID store's registered read port: stage one, output register.
// Throughput: one beat per cycle unless out_stall holds the output beat with stage one full.
// Reset (synchronous): command phase, counters zero, ID store reads all zeros at once
// through its valid bits, registers back to their defaults; no clearing pass.
`include "spi_flash_challenge_responder_unit_defines.svh"
module spi_flash_challenge_responder_unit #(
  parameter int ID_BYTES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sfcr_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sfcr_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sfcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfcr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sfcr_pkg::*;

  localparam int AW = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;

  logic          go;
  logic          out_load;
  logic          s1_valid;
  issue_t        issue;
  issue_t        s1_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [6:0]    wr_data;
  logic [6:0]    rd_data;
  logic [23:0]   serial_number;
  logic [7:0]    status_reply;
  logic [7:0]    code_idx;
  logic [7:0]    tx_next;

  // Configuration registers; the port always takes a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_number <= SERIAL_RESET;
      status_reply  <= STATUS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SERIAL) begin
        serial_number <= cfg_data[23:0];
      end
      if (cfg_index == REG_STATUS) begin
        status_reply <= cfg_data[7:0];
      end
    end
  end

  // Flow control: stage one stalls only when it is full and the output beat is held.
  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign go       = in_valid && !in_stall;

  sfcr_seq #(
    .ID_BYTES (ID_BYTES),
    .AW       (AW)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .in_data       (in_data),
    .serial_number (serial_number),
    .status_reply  (status_reply),
    .issue         (issue),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  sfcr_id_store #(
    .ID_BYTES (ID_BYTES),
    .AW       (AW)
  ) u_id_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stage one: issued work, captured alongside the store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (go) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_q <= issue;
    end
  end

  // Stage two: pick the result byte, coding through the table where needed.
  assign code_idx = {1'b0, rd_data} + {1'b0, s1_q.pos};

  always_comb begin
    unique case (s1_q.src)
      SRC_ID:    tx_next = {1'b0, rd_data};
      SRC_CODED: tx_next = CODE_TABLE[code_idx];
      default:   tx_next = s1_q.byte_val;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.tx_byte <= tx_next;
      out_data.in_run  <= s1_q.in_run;
    end
  end

  // An accepted beat always lands in stage one.
  `SFCR_ASSERT(a_go_fills_s1, go |=> s1_valid)
  // Stage one holds its work until the output stage takes it.
  `SFCR_ASSERT(a_s1_holds, (s1_valid && !out_load) |=> (s1_valid && $stable(s1_q)))
  // A beat moved into the output register is presented next cycle.
  `SFCR_ASSERT(a_out_loaded, out_load |=> out_valid)
  // The input is never stalled while stage one is empty.
  `SFCR_NEVER(a_no_idle_stall, in_stall && !s1_valid)

endmodule

// File: rtl/sfcr_id_store.sv
`timescale 1ns / 1ps
// Device ID store: one write port, one registered read port, per-entry valid bits.
// Depends on nothing but its parameters; an entry never written reads as zero.
module sfcr_id_store #(
  parameter int ID_BYTES = 64,
  parameter int AW       = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [6:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [6:0]    rd_data
);

  logic [6:0]          mem [ID_BYTES];
  logic [ID_BYTES-1:0] id_valid;
  logic [6:0]          rd_q;
  logic                rd_hit;

  // Storage array write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits stand in for the all-zero reset contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      id_valid <= '0;
    end else if (wr_en) begin
      id_valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read; data holds while no new read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_hit <= id_valid[rd_addr];
    end
  end

  assign rd_data = rd_hit ? rd_q : 7'd0;

endmodule

// File: rtl/sfcr_seq.sv
`timescale 1ns / 1ps
// Run sequencer: phase and position counters, command decode, store addressing.
// Uses sfcr_pkg for beat types, function codes and command codes.
module sfcr_seq #(
  parameter int ID_BYTES = 64,
  parameter int AW       = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  sfcr_pkg::in_t         in_data,
  input  logic [23:0]           serial_number,
  input  logic [7:0]            status_reply,
  output sfcr_pkg::issue_t      issue,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [6:0]            wr_data
);
  import sfcr_pkg::*;

  localparam logic [1:0]    PH_CMD   = 2'd0;
  localparam logic [1:0]    PH_LEAD  = 2'd1;
  localparam logic [1:0]    PH_CHAL  = 2'd2;
  localparam logic [7:0]    ID_BASE  = 8'(CHALLENGE_LEN - ID_BYTES);
  localparam logic [AW-1:0] MOD_LAST = AW'(ID_BYTES - 1);

  logic [1:0]    phase, phase_next;
  logic [6:0]    run_count, run_count_next;
  logic [AW-1:0] mod_count, mod_count_next;
  logic [7:0]    count_inc;
  logic [7:0]    pos_ext;
  logic [7:0]    id_off;
  logic [7:0]    idx_ext;
  logic [7:0]    serial_pick;
  logic          rd_req;
  logic          wr_req;

  assign pos_ext   = {1'b0, run_count};
  assign count_inc = pos_ext + 8'd1;
  assign id_off    = pos_ext - ID_BASE;
  assign idx_ext   = {2'b00, in_data.id_index};

  // Serial number byte for the first three challenge positions.
  always_comb begin
    unique case (run_count[1:0])
      2'd0:    serial_pick = serial_number[23:16];
      2'd1:    serial_pick = serial_number[15:8];
      default: serial_pick = serial_number[7:0];
    endcase
  end

  // Next state and issued work for the beat at the input.
  always_comb begin
    phase_next     = phase;
    run_count_next = run_count;
    mod_count_next = mod_count;
    issue.src      = SRC_DIRECT;
    issue.byte_val = 8'd0;
    issue.pos      = run_count;
    rd_req         = 1'b0;
    rd_addr        = mod_count;
    wr_req         = 1'b0;
    wr_addr        = idx_ext[AW-1:0];
    wr_data        = in_data.id_value;
    unique case (in_data.func)
      FUNC_BYTE: begin
        unique case (phase)
          PH_LEAD: begin
            run_count_next = count_inc[6:0];
            if (count_inc >= 8'(LEAD_ZEROS)) begin
              phase_next     = PH_CHAL;
              run_count_next = '0;
              mod_count_next = '0;
            end
          end
          PH_CHAL: begin
            if (pos_ext < 8'(LEAD_ZEROS)) begin
              issue.byte_val = serial_pick;
            end else if (pos_ext >= ID_BASE) begin
              issue.src = SRC_ID;
              rd_req    = 1'b1;
              rd_addr   = id_off[AW-1:0];
            end else begin
              issue.src = SRC_CODED;
              rd_req    = 1'b1;
            end
            run_count_next = count_inc[6:0];
            mod_count_next = (mod_count == MOD_LAST) ? '0 : mod_count + AW'(1);
            if (count_inc >= 8'(CHALLENGE_LEN)) begin
              phase_next     = PH_CMD;
              run_count_next = '0;
              mod_count_next = '0;
            end
          end
          default: begin
            // Command phase; the unused phase code behaves the same.
            phase_next = PH_CMD;
            if (in_data.rx_byte == CMD_READ_STATUS) begin
              issue.byte_val = status_reply;
            end else begin
              issue.byte_val = in_data.rx_byte;
              if (in_data.rx_byte == CMD_DUMP) begin
                phase_next     = PH_LEAD;
                run_count_next = '0;
              end
            end
          end
        endcase
      end
      FUNC_LOAD: begin
        wr_req = (idx_ext < 8'(ID_BYTES));
      end
      FUNC_DESELECT: begin
        phase_next     = PH_CMD;
        run_count_next = '0;
        mod_count_next = '0;
      end
      default: begin
      end
    endcase
    issue.in_run = (phase_next == PH_LEAD) || (phase_next == PH_CHAL);
  end

  assign rd_en = go && rd_req;
  assign wr_en = go && wr_req;

  // Phase and position registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CMD;
      run_count <= '0;
      mod_count <= '0;
    end else if (go) begin
      phase     <= phase_next;
      run_count <= run_count_next;
      mod_count <= mod_count_next;
    end
  end

endmodule
